// ===== hw/rtl/gvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared types, codes and constants of the gravity vector compensation block.
// ----------------------------------------------------------------------------
package gvc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DIR_FRAC   = 14;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [16:0] ALPHA_ONE     = 17'd65536;
  localparam logic [16:0] ALPHA_RESET   = 17'd6554;
  localparam logic [15:0] GREF_RESET    = 16'd0;
  localparam logic [15:0] DZONE_RESET   = 16'd205;
  localparam logic [16:0] LEVEL_RESET   = 17'd10042;

  localparam logic [1:0] OP_MEASURE = 2'd0;
  localparam logic [1:0] OP_CAL     = 2'd1;
  localparam logic [1:0] OP_SMOOTH  = 2'd2;

  localparam logic [1:0] ST_MEASURED = 2'd0;
  localparam logic [1:0] ST_CAL      = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_GREF  = 2'd1;
  localparam logic [1:0] REG_DZONE = 2'd2;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } gvc_in_t;

  typedef struct packed {
    logic signed [17:0] linear_accel;
    logic [16:0]        magnitude;
    logic [1:0]         status;
  } gvc_out_t;

  typedef struct packed {
    logic [16:0] alpha;
    logic [15:0] g_ref;
    logic [15:0] dead_zone;
  } gvc_cfg_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_SQ, DP_SQRT_INIT, DP_SQRT_STEP, DP_RES_ZERO, DP_RES_CAL,
    DP_MAC, DP_MEAS, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_STORE, DP_COMMIT,
    DP_BLEND_A, DP_BLEND_B, DP_EMIT
  } gvc_cmd_e;

  typedef struct packed {
    gvc_cmd_e   cmd;
    logic [1:0] idx;
  } gvc_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       mag_zero;
  } gvc_sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT_INIT, S_SQRT, S_BRANCH, S_MAC, S_MEAS, S_DIV_INIT,
    S_DIV, S_DIV_STORE, S_COMMIT, S_BLEND_A, S_BLEND_B, S_DONE
  } gvc_state_e;

endpackage

// ===== hw/rtl/gravity_vector_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_vector_compensation
// Removes gravity from accelerometer samples by projection onto a learned
// gravity direction, with calibrate and smooth calibrate operations.
// ----------------------------------------------------------------------------
// Items are taken one at a time: in_stall stays high from acceptance until
// the result is written to the result register, so a stalled output also
// holds the input. The time per item is set by the bit-serial square root
// (16 steps) and, for both calibrate operations, the three 15-step divisions.
// Reset clears direction to zero, level to 10042 and registers to defaults.
// ----------------------------------------------------------------------------
module gravity_vector_compensation import gvc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gvc_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gvc_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  gvc_cfg_t cfg_r;
  gvc_cmd_t cmd;
  gvc_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha     <= ALPHA_RESET;
      cfg_r.g_ref     <= GREF_RESET;
      cfg_r.dead_zone <= DZONE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ALPHA: cfg_r.alpha     <= pwdata[16:0];
        REG_GREF:  cfg_r.g_ref     <= pwdata[15:0];
        REG_DZONE: cfg_r.dead_zone <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALPHA: prdata = {15'd0, cfg_r.alpha};
      REG_GREF:  prdata = {16'd0, cfg_r.g_ref};
      REG_DZONE: prdata = {16'd0, cfg_r.dead_zone};
      default:   prdata = '0;
    endcase
  end

  gvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gvc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/gvc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_ctrl
// Sequencer for the square sum, square root, divisions, blend and projection.
// ----------------------------------------------------------------------------
module gvc_ctrl import gvc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  gvc_sts_t sts,
  output gvc_cmd_t cmd
);

  gvc_state_e state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.cmd       = DP_NOP;
    cmd.idx       = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cmd   = DP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.cmd = DP_SQ;
        cmd.idx = cnt_r[1:0];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd2) begin
          state_nxt = S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd.cmd   = DP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.cmd = DP_SQRT_STEP;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_BRANCH;
        end
      end
      S_BRANCH: begin
        idx_nxt = '0;
        cnt_nxt = '0;
        if (sts.op != OP_CAL && sts.op != OP_SMOOTH) begin
          state_nxt = S_MAC;
        end else if (sts.mag_zero) begin
          cmd.cmd   = DP_RES_ZERO;
          state_nxt = S_DONE;
        end else begin
          cmd.cmd   = DP_RES_CAL;
          state_nxt = S_DIV_INIT;
        end
      end
      S_MAC: begin
        cmd.cmd = DP_MAC;
        cmd.idx = cnt_r[1:0];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd2) begin
          state_nxt = S_MEAS;
        end
      end
      S_MEAS: begin
        cmd.cmd   = DP_MEAS;
        state_nxt = S_DONE;
      end
      S_DIV_INIT: begin
        cmd.cmd   = DP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.cmd = DP_DIV_STEP;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd14) begin
          state_nxt = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        cmd.cmd = DP_DIV_STORE;
        if (idx_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = (sts.op == OP_CAL) ? S_COMMIT : S_BLEND_A;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_DIV_INIT;
        end
      end
      S_COMMIT: begin
        cmd.cmd   = DP_COMMIT;
        state_nxt = S_DONE;
      end
      S_BLEND_A: begin
        cmd.cmd   = DP_BLEND_A;
        state_nxt = S_BLEND_B;
      end
      S_BLEND_B: begin
        cmd.cmd = DP_BLEND_B;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BLEND_A;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.cmd       = DP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gvc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_datapath
// Shared multiplier, bit-serial square root and divider, and gravity state.
// ----------------------------------------------------------------------------
module gvc_datapath import gvc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  gvc_in_t  in_data,
  input  gvc_cfg_t cfg,
  input  gvc_cmd_t cmd,
  output gvc_sts_t sts,
  output gvc_out_t out_data
);

  gvc_in_t            smp_r;
  logic signed [37:0] acc_r;
  logic [31:0]        sq_r;
  logic [17:0]        srem_r;
  logic [15:0]        root_r;
  logic [15:0]        drem_r;
  logic [14:0]        numsh_r;
  logic [14:0]        q_r;
  logic signed [15:0] nd_r [3];
  logic signed [15:0] dir_r [3];
  logic [16:0]        level_r;
  logic signed [17:0] res_lin_r;
  logic [1:0]         res_st_r;
  gvc_out_t           out_r;

  logic signed [15:0] a_sel;
  logic [15:0]        a_abs;
  logic [29:0]        num;
  logic [16:0]        al;
  logic [16:0]        inv_al;
  logic [16:0]        target;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic signed [37:0] bsum, bres, vert, diff, adiff;
  logic [19:0]        st_t, st_trial;
  logic [16:0]        dt;
  logic signed [17:0] lin;

  always_comb begin
    case (cmd.idx)
      2'd0:    a_sel = smp_r.accel_x;
      2'd1:    a_sel = smp_r.accel_y;
      default: a_sel = smp_r.accel_z;
    endcase
  end

  assign a_abs  = a_sel[15] ? 16'(-a_sel) : 16'(a_sel);
  assign num    = {a_abs, 14'd0} + {15'd0, root_r[15:1]};
  assign al     = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign inv_al = ALPHA_ONE - al;
  assign target = (cfg.g_ref != 16'd0) ? {1'b0, cfg.g_ref} : {1'b0, root_r};

  always_comb begin
    mul_a = {{2{a_sel[15]}}, a_sel};
    mul_b = {{2{a_sel[15]}}, a_sel};
    case (cmd.cmd)
      DP_MAC: begin
        mul_b = (cmd.idx == 2'd3) ? 18'sd0 : 18'(dir_r[cmd.idx]);
      end
      DP_BLEND_A: begin
        mul_a = $signed({1'b0, al});
        mul_b = (cmd.idx == 2'd3) ? $signed({1'b0, target}) : 18'(nd_r[cmd.idx]);
      end
      DP_BLEND_B: begin
        mul_a = $signed({1'b0, inv_al});
        mul_b = (cmd.idx == 2'd3) ? $signed({1'b0, level_r}) : 18'(dir_r[cmd.idx]);
      end
      default: begin
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign bsum     = acc_r + 38'(prod);
  assign bres     = bsum >>> 16;
  assign st_t     = {srem_r[17:0], sq_r[31:30]};
  assign st_trial = {2'b00, root_r, 2'b01};
  assign dt       = {drem_r, numsh_r[14]};
  assign vert     = (acc_r + 38'sd8192) >>> DIR_FRAC;
  assign diff     = vert - $signed({21'd0, level_r});
  assign adiff    = diff[37] ? -diff : diff;

  always_comb begin
    if (adiff < $signed({22'd0, cfg.dead_zone})) begin
      lin = '0;
    end else if (diff > 38'sd131071) begin
      lin = 18'sd131071;
    end else if (diff < -38'sd131072) begin
      lin = -18'sd131072;
    end else begin
      lin = diff[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= '0;
      level_r  <= LEVEL_RESET;
    end else begin
      case (cmd.cmd)
        DP_COMMIT: begin
          dir_r[0] <= nd_r[0];
          dir_r[1] <= nd_r[1];
          dir_r[2] <= nd_r[2];
          level_r  <= target;
        end
        DP_BLEND_B: begin
          if (cmd.idx == 2'd3) begin
            level_r <= bres[16:0];
          end else begin
            dir_r[cmd.idx] <= bres[15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.cmd)
      DP_LOAD: smp_r <= in_data;
      DP_SQ: acc_r <= (cmd.idx == 2'd0) ? 38'(prod) : bsum;
      DP_MAC: acc_r <= (cmd.idx == 2'd0) ? 38'(prod) : bsum;
      DP_SQRT_INIT: begin
        sq_r   <= acc_r[31:0];
        srem_r <= '0;
        root_r <= '0;
      end
      DP_SQRT_STEP: begin
        sq_r <= {sq_r[29:0], 2'b00};
        if (st_t >= st_trial) begin
          srem_r <= 18'(st_t - st_trial);
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          srem_r <= st_t[17:0];
          root_r <= {root_r[14:0], 1'b0};
        end
      end
      DP_RES_ZERO: begin
        res_lin_r <= '0;
        res_st_r  <= ST_ZERO;
      end
      DP_RES_CAL: begin
        res_lin_r <= '0;
        res_st_r  <= ST_CAL;
      end
      DP_MEAS: begin
        res_lin_r <= lin;
        res_st_r  <= ST_MEASURED;
      end
      DP_DIV_INIT: begin
        drem_r  <= {1'b0, num[29:15]};
        numsh_r <= num[14:0];
        q_r     <= '0;
      end
      DP_DIV_STEP: begin
        numsh_r <= {numsh_r[13:0], 1'b0};
        if (dt >= {1'b0, root_r}) begin
          drem_r <= 16'(dt - {1'b0, root_r});
          q_r    <= {q_r[13:0], 1'b1};
        end else begin
          drem_r <= dt[15:0];
          q_r    <= {q_r[13:0], 1'b0};
        end
      end
      DP_DIV_STORE: begin
        if (cmd.idx != 2'd3) begin
          nd_r[cmd.idx] <= a_sel[15] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
        end
      end
      DP_BLEND_A: acc_r <= 38'(prod) + 38'sd32768;
      DP_EMIT: begin
        out_r.linear_accel <= res_lin_r;
        out_r.magnitude    <= (res_st_r == ST_ZERO) ? 17'd0 : {1'b0, root_r};
        out_r.status       <= res_st_r;
      end
      default: begin
      end
    endcase
  end

  assign sts.op       = smp_r.opcode;
  assign sts.mag_zero = (root_r == 16'd0);
  assign out_data     = out_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gravity vector compensation testbench
// Drives measure, calibrate and smooth calibrate items under random gaps and
// output stalls, writes all registers through the APB port between phases,
// and compares every result field with a fixed-point prediction of the block.
// ----------------------------------------------------------------------------
module testbench import gvc_pkg::*; ();

  class gravity_scoreboard;
    logic [16:0] alpha;
    logic [15:0] g_ref;
    logic [15:0] dzone;
    longint dir [3];
    longint level;
    gvc_out_t pending[$];
    int mismatches;
    int checked;

    function new();
      alpha = ALPHA_RESET;
      g_ref = GREF_RESET;
      dzone = DZONE_RESET;
      dir[0] = 0;
      dir[1] = 0;
      dir[2] = 0;
      level = LEVEL_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function longint floor_div(longint v, int sh);
      longint d;
      d = longint'(1) << sh;
      if (v >= 0) return v / d;
      return -((-v + d - 1) / d);
    endfunction

    function longint int_sqrt(longint n);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint blend(longint nv, longint ov, longint al);
      return floor_div(al * nv + (65536 - al) * ov + 32768, 16);
    endfunction

    function void note_sample(gvc_in_t it);
      longint a [3];
      longint mag;
      longint magsat;
      longint nd [3];
      longint tgt;
      longint al;
      longint v;
      longint r;
      gvc_out_t res;
      a[0] = it.accel_x;
      a[1] = it.accel_y;
      a[2] = it.accel_z;
      mag = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      magsat = mag > 131071 ? 131071 : mag;
      res.linear_accel = '0;
      res.magnitude = magsat[16:0];
      if (it.opcode == OP_CAL || it.opcode == OP_SMOOTH) begin
        if (mag == 0) begin
          res.status = ST_ZERO;
          res.magnitude = '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            v = (((a[i] < 0 ? -a[i] : a[i]) << DIR_FRAC) + (mag >> 1)) / mag;
            nd[i] = a[i] < 0 ? -v : v;
          end
          tgt = g_ref != 0 ? longint'(g_ref) : magsat;
          if (it.opcode == OP_CAL) begin
            for (int i = 0; i < 3; i++) dir[i] = nd[i];
            level = tgt;
          end else begin
            al = alpha > ALPHA_ONE ? 65536 : longint'(alpha);
            for (int i = 0; i < 3; i++) dir[i] = blend(nd[i], dir[i], al);
            level = blend(tgt, level, al);
            if (level < 0) level = 0;
            if (level > 131071) level = 131071;
          end
          res.status = ST_CAL;
        end
      end else begin
        v = a[0] * dir[0] + a[1] * dir[1] + a[2] * dir[2];
        r = floor_div(v + (longint'(1) << (DIR_FRAC - 1)), DIR_FRAC) - level;
        if ((r < 0 ? -r : r) < longint'(dzone)) r = 0;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        res.linear_accel = r[17:0];
        res.status = ST_MEASURED;
      end
      pending.push_back(res);
    endfunction

    function void check_result(gvc_out_t got);
      gvc_out_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h.", got);
        return;
      end
      want = pending.pop_front();
      if (got.linear_accel !== want.linear_accel || got.magnitude !== want.magnitude ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected lin %0d mag %0d st %0d, got lin %0d mag %0d st %0d.",
                   want.linear_accel, want.magnitude, want.status,
                   got.linear_accel, got.magnitude, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  gvc_in_t in_data;
  logic out_valid;
  logic out_stall;
  gvc_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  gravity_scoreboard board;

  gravity_vector_compensation uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ALPHA: board.alpha = value[16:0];
      REG_GREF: board.g_ref = value[15:0];
      default: board.dzone = value[15:0];
    endcase
  endtask

  task automatic send_sample(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    repeat (g) @(posedge clk);
    in_data <= {op, x, y, z};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_sample({op, x, y, z});
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (board.pending.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
  endtask

  function logic [15:0] rand_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 5) return 16'($signed($urandom_range(0, 4000)) - 2000);
    return 16'($urandom);
  endfunction

  task automatic random_phase(int count);
    logic [1:0] op;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      op = r < 65 ? OP_MEASURE : r < 80 ? OP_CAL : r < 96 ? OP_SMOOTH : 2'd3;
      if ($urandom_range(0, 29) == 0)
        send_sample(op, 16'd0, 16'd0, 16'd0, 1);
      else if ($urandom_range(0, 3) == 0 && op != OP_MEASURE)
        send_sample(op, 16'($signed($urandom_range(0, 600)) - 300),
                    16'($signed($urandom_range(0, 600)) - 300),
                    16'($urandom_range(9000, 11000)), 1);
      else
        send_sample(op, rand_axis(), rand_axis(), rand_axis(), 1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(OP_MEASURE, 16'd0, 16'd0, 16'd0, 0);
    send_sample(OP_CAL, 16'd0, 16'd0, 16'd0, 0);
    send_sample(OP_SMOOTH, 16'd0, 16'd0, 16'd0, 0);
    send_sample(OP_CAL, 16'd0, 16'd0, 16'd10042, 0);
    send_sample(OP_MEASURE, 16'd0, 16'd0, 16'd10100, 0);
    send_sample(OP_MEASURE, 16'd0, 16'd0, 16'd12000, 0);
    send_sample(OP_MEASURE, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_sample(OP_CAL, 16'h8000, 16'h8000, 16'h8000, 0);
    send_sample(OP_MEASURE, 16'h8000, 16'h8000, 16'h8000, 0);
    send_sample(OP_MEASURE, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_sample(OP_SMOOTH, 16'd3, 16'hfffb, 16'd7, 0);
    send_sample(2'd3, 16'd100, 16'd200, 16'hff00, 0);
    send_sample(OP_CAL, 16'd1, 16'd1, 16'd1, 0);
    send_sample(OP_MEASURE, 16'd0, 16'd0, 16'd1, 0);
    drain();

    write_reg(REG_ALPHA, 32'h1ffff);
    write_reg(REG_GREF, 32'd9810);
    write_reg(REG_DZONE, 32'd0);
    send_sample(OP_SMOOTH, 16'd200, 16'hff38, 16'd9900, 0);
    send_sample(OP_MEASURE, 16'd0, 16'd0, 16'd9810, 0);
    random_phase(200);
    drain();

    write_reg(REG_ALPHA, 32'd0);
    write_reg(REG_GREF, 32'hffff);
    write_reg(REG_DZONE, 32'hffff);
    random_phase(150);
    drain();

    write_reg(REG_ALPHA, 32'd65536);
    write_reg(REG_GREF, 32'd0);
    write_reg(REG_DZONE, 32'd50);
    random_phase(250);
    drain();

    write_reg(REG_ALPHA, 32'h0_5555 & 32'h1ffff);
    write_reg(REG_GREF, 32'haaaa);
    write_reg(REG_DZONE, 32'h5555);
    random_phase(150);
    drain();

    write_reg(REG_ALPHA, 32'($urandom_range(1, 65535)));
    write_reg(REG_GREF, 32'd0);
    write_reg(REG_DZONE, 32'd205);
    random_phase(150);
    drain();

    $display("Checked %0d results over measure, calibrate, smooth and zero samples,",
             board.checked);
    $display("with register settings from zero to full scale and random stalls.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      g = $urandom_range(0, 99);
      if (g < 50) out_stall <= 1'b0;
      else if (g < 97) out_stall <= 1'b1;
      else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 150)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
